// ===== rtl/rrpc_pkg.sv =====
// Package for the range rescale block: state codes, register indexes, constants and exp2 ROM.
package rrpc_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MULCA,
    ST_DIV,
    ST_DROUND,
    ST_CAP,
    ST_NORM,
    ST_LOGSQ,
    ST_PMUL,
    ST_EXP,
    ST_CMUL,
    ST_ROUND,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_STORE_CONV = 2'd0;
  localparam logic [1:0] OP_STORE      = 2'd1;
  localparam logic [1:0] OP_HELD       = 2'd2;
  localparam logic [1:0] OP_LIST       = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MIN_IN   = 3'd0;
  localparam logic [2:0] CFG_MAX_IN   = 3'd1;
  localparam logic [2:0] CFG_MIN_OUT  = 3'd2;
  localparam logic [2:0] CFG_MAX_OUT  = 3'd3;
  localparam logic [2:0] CFG_EXPONENT = 3'd4;
  localparam logic [2:0] CFG_CLIP     = 3'd5;

  // Register reset values (max_in defaults to 127.0, max_out to 1.0).
  localparam logic [31:0] MAX_IN_RST  = 32'd127 << 16;
  localparam logic [31:0] MAX_OUT_RST = 32'd65536;
  localparam logic [23:0] EXP_ONE     = 24'd65536;

  // Largest magnitude before the sign is applied.
  localparam logic [63:0] MAG_CAP = 64'd1 << 34;

  // Number of fraction bits in the log and exp2 steps.
  localparam int FRAC_BITS = 20;

  typedef logic [FRAC_BITS-1:0][31:0] exp2_rom_t;

  // Integer square root, evaluated only at elaboration.
  function automatic logic [63:0] isqrt_f(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = v;
    res   = 64'd0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > rem) begin
        bit_v = bit_v >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (rem >= res + bit_v) begin
          rem = rem - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // Entry k holds 2^(2^-(k+1)) in Q2.30, each the root of the one before.
  function automatic exp2_rom_t exp2_rom_f();
    exp2_rom_t   rom;
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int k = 0; k < FRAC_BITS; k++) begin
      r      = isqrt_f(r << 30);
      rom[k] = r[31:0];
    end
    return rom;
  endfunction

  localparam exp2_rom_t EXP2_ROM = exp2_rom_f();

endpackage

// ===== rtl/range_rescale_power_curve.sv =====
// Top level of the range rescale block with power curve, one shared multiplier under a sequencer.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_op, in_sample_in, in_last_in
//  out_    | output    | out_valid/out_stall| out_sample_out, out_range_error, out_last_out
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A store-only beat leaves the sequencer idle; a beat at min_in or with a zero range or span
// goes from ST_PREP straight to ST_FINISH. A conversion with exponent 1.0 uses the 64-step
// restoring divider. Other exponents use a one-bit-a-cycle normalize of both operands
// plus 62 steps on the single 33x33 multiplier.
// Synchronous active-low reset restores the sequencer, configuration, held value and out_valid.
// No input beat is taken while a conversion runs; a finished result waits in the output
// register while the next beat is taken; out_stall delays its hand-off and stalls ST_FINISH.
module range_rescale_power_curve (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_sample_in,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_sample_out,
  output logic        out_range_error,
  output logic        out_last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  rrpc_pkg::state_t state_r, state_nxt;

  // Configuration and held value.
  logic signed [31:0] min_in_r, max_in_r, min_out_r, max_out_r, held_r;
  logic [23:0]        exp_r;
  logic               clip_r;

  // Datapath registers.
  logic signed [31:0] v_r;
  logic               last_r, err_r, neg_r, direct_r, second_r;
  logic [31:0]        a_r, b_r, c_r, m_r, rem_r, acc_r;
  logic [4:0]         lz_r;
  logic [19:0]        frac_r, f_r;
  logic [24:0]        la_r, lb_r;
  logic [5:0]         cnt_r;
  logic signed [49:0] p_r;
  logic [63:0]        prod_r;
  logic [34:0]        mag_r;

  // Output register.
  logic               out_valid_r, out_err_r, out_last_r;
  logic [31:0]        out_sample_r;

  logic in_accept, out_take, cfg_we;
  logic signed [32:0] diff_w, range_w, span_w;
  logic [31:0]        a_w, b_w, c_w;
  logic signed [32:0] mul_a_w, mul_b_w;
  logic signed [65:0] mul_p_w;
  logic signed [25:0] l_w;
  logic [32:0]        sq_w, rem_sh_w;
  logic               ge_w, rnd_w, sq_bit_w, finish_go_w;
  logic [24:0]        lg_w;
  logic signed [13:0] ip_w;
  logic signed [14:0] s_w, shr_w;
  logic signed [31:0] result_w;
  logic signed [35:0] sum_w;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_range_error = out_err_r;
  assign out_last_out    = out_last_r;

  // Range differences and their magnitudes.
  assign diff_w  = {v_r[31], v_r} - {min_in_r[31], min_in_r};
  assign range_w = {max_in_r[31], max_in_r} - {min_in_r[31], min_in_r};
  assign span_w  = {max_out_r[31], max_out_r} - {min_out_r[31], min_out_r};
  assign a_w = diff_w[32]  ? 32'(-diff_w)  : diff_w[31:0];
  assign b_w = range_w[32] ? 32'(-range_w) : range_w[31:0];
  assign c_w = span_w[32]  ? 32'(-span_w)  : span_w[31:0];

  // Divider step, log squaring step and shift amounts.
  assign rem_sh_w = {rem_r, prod_r[63]};
  assign ge_w     = rem_sh_w >= {1'b0, b_r};
  assign rnd_w    = {rem_r, 1'b0} >= {1'b0, b_r};
  assign sq_w     = mul_p_w[63:31];
  assign sq_bit_w = sq_w[32];
  assign lg_w     = {~lz_r, frac_r[18:0], sq_bit_w};
  assign l_w      = $signed({1'b0, la_r}) - $signed({1'b0, lb_r});
  assign ip_w     = p_r[49:36];
  assign s_w      = {ip_w[13], ip_w} - 15'sd30;
  assign shr_w    = -s_w;
  assign mul_p_w  = mul_a_w * mul_b_w;
  assign finish_go_w = !out_valid_r || !out_stall;

  // Shared multiplier operand selection and input stall.
  always_comb begin
    in_stall = (state_r != rrpc_pkg::ST_IDLE);
    mul_a_w  = '0;
    mul_b_w  = '0;
    unique case (state_r)
      rrpc_pkg::ST_MULCA: begin
        mul_a_w = $signed({1'b0, c_r});
        mul_b_w = $signed({1'b0, a_r});
      end
      rrpc_pkg::ST_LOGSQ: begin
        mul_a_w = $signed({1'b0, m_r});
        mul_b_w = $signed({1'b0, m_r});
      end
      rrpc_pkg::ST_PMUL: begin
        mul_a_w = 33'(l_w);
        mul_b_w = $signed({9'd0, exp_r});
      end
      rrpc_pkg::ST_EXP: begin
        mul_a_w = $signed({1'b0, acc_r});
        mul_b_w = $signed({1'b0, rrpc_pkg::EXP2_ROM[cnt_r[4:0]]});
      end
      rrpc_pkg::ST_CMUL: begin
        mul_a_w = $signed({1'b0, c_r});
        mul_b_w = $signed({1'b0, acc_r});
      end
      default: begin
      end
    endcase
  end

  // Final sum, saturation and clipping.
  always_comb begin
    sum_w = neg_r ? (36'(min_out_r) - $signed({1'b0, mag_r}))
                  : (36'(min_out_r) + $signed({1'b0, mag_r}));
    if (direct_r) begin
      result_w = min_out_r;
    end else if (sum_w > 36'sd2147483647) begin
      result_w = 32'sh7FFFFFFF;
    end else if (sum_w < -36'sd2147483648) begin
      result_w = 32'sh80000000;
    end else begin
      result_w = sum_w[31:0];
    end
    if (clip_r) begin
      if (result_w < min_out_r) begin
        result_w = min_out_r;
      end
      if (result_w > max_out_r) begin
        result_w = max_out_r;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrpc_pkg::ST_IDLE: begin
        if (in_accept && in_op != rrpc_pkg::OP_STORE) begin
          state_nxt = rrpc_pkg::ST_PREP;
        end
      end
      rrpc_pkg::ST_PREP: begin
        if (diff_w == '0 || range_w == '0 || span_w == '0) begin
          state_nxt = rrpc_pkg::ST_FINISH;
        end else if (exp_r == rrpc_pkg::EXP_ONE) begin
          state_nxt = rrpc_pkg::ST_MULCA;
        end else begin
          state_nxt = rrpc_pkg::ST_NORM;
        end
      end
      rrpc_pkg::ST_MULCA:  state_nxt = rrpc_pkg::ST_DIV;
      rrpc_pkg::ST_DIV: begin
        if (cnt_r == 6'd63) begin
          state_nxt = rrpc_pkg::ST_DROUND;
        end
      end
      rrpc_pkg::ST_DROUND: state_nxt = rrpc_pkg::ST_CAP;
      rrpc_pkg::ST_CAP:    state_nxt = rrpc_pkg::ST_FINISH;
      rrpc_pkg::ST_NORM: begin
        if (m_r[31]) begin
          state_nxt = rrpc_pkg::ST_LOGSQ;
        end
      end
      rrpc_pkg::ST_LOGSQ: begin
        if (cnt_r == 6'(rrpc_pkg::FRAC_BITS - 1)) begin
          state_nxt = second_r ? rrpc_pkg::ST_PMUL : rrpc_pkg::ST_NORM;
        end
      end
      rrpc_pkg::ST_PMUL:   state_nxt = rrpc_pkg::ST_EXP;
      rrpc_pkg::ST_EXP: begin
        if (cnt_r == 6'(rrpc_pkg::FRAC_BITS - 1)) begin
          state_nxt = rrpc_pkg::ST_CMUL;
        end
      end
      rrpc_pkg::ST_CMUL:   state_nxt = rrpc_pkg::ST_ROUND;
      rrpc_pkg::ST_ROUND:  state_nxt = rrpc_pkg::ST_SHIFT;
      rrpc_pkg::ST_SHIFT:  state_nxt = rrpc_pkg::ST_CAP;
      rrpc_pkg::ST_FINISH: begin
        if (finish_go_w) begin
          state_nxt = rrpc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rrpc_pkg::ST_IDLE;
    endcase
  end

  // Control state, configuration registers, held value and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrpc_pkg::ST_IDLE;
      min_in_r    <= '0;
      max_in_r    <= rrpc_pkg::MAX_IN_RST;
      min_out_r   <= '0;
      max_out_r   <= rrpc_pkg::MAX_OUT_RST;
      exp_r       <= rrpc_pkg::EXP_ONE;
      clip_r      <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rrpc_pkg::CFG_MIN_IN:   min_in_r  <= cfg_data;
          rrpc_pkg::CFG_MAX_IN:   max_in_r  <= cfg_data;
          rrpc_pkg::CFG_MIN_OUT:  min_out_r <= cfg_data;
          rrpc_pkg::CFG_MAX_OUT:  max_out_r <= cfg_data;
          rrpc_pkg::CFG_EXPONENT: exp_r     <= cfg_data[23:0];
          rrpc_pkg::CFG_CLIP:     clip_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (in_accept && (in_op == rrpc_pkg::OP_STORE_CONV || in_op == rrpc_pkg::OP_STORE)) begin
        held_r <= in_sample_in;
      end
      if (state_r == rrpc_pkg::ST_FINISH && finish_go_w) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      rrpc_pkg::ST_IDLE: begin
        if (in_accept) begin
          v_r    <= (in_op == rrpc_pkg::OP_HELD) ? held_r : in_sample_in;
          last_r <= (in_op == rrpc_pkg::OP_LIST) ? in_last_in : 1'b1;
        end
      end
      rrpc_pkg::ST_PREP: begin
        a_r      <= a_w;
        b_r      <= b_w;
        c_r      <= c_w;
        neg_r    <= diff_w[32] ^ range_w[32] ^ span_w[32];
        err_r    <= (range_w == '0);
        direct_r <= (diff_w == '0) || (range_w == '0);
        mag_r    <= '0;
        m_r      <= a_w;
        lz_r     <= '0;
        second_r <= 1'b0;
      end
      rrpc_pkg::ST_MULCA: begin
        prod_r <= mul_p_w[63:0];
        rem_r  <= '0;
        cnt_r  <= '0;
      end
      // One quotient bit per cycle, quotient shifts in behind the dividend.
      rrpc_pkg::ST_DIV: begin
        rem_r  <= ge_w ? 32'(rem_sh_w - {1'b0, b_r}) : rem_sh_w[31:0];
        prod_r <= {prod_r[62:0], ge_w};
        cnt_r  <= cnt_r + 6'd1;
      end
      rrpc_pkg::ST_DROUND: begin
        prod_r <= prod_r + {63'd0, rnd_w};
      end
      rrpc_pkg::ST_CAP: begin
        mag_r <= (prod_r > rrpc_pkg::MAG_CAP) ? rrpc_pkg::MAG_CAP[34:0] : prod_r[34:0];
      end
      // Bring the leading one to the top, one bit a cycle.
      rrpc_pkg::ST_NORM: begin
        if (m_r[31]) begin
          cnt_r  <= '0;
          frac_r <= '0;
        end else begin
          m_r  <= {m_r[30:0], 1'b0};
          lz_r <= lz_r + 5'd1;
        end
      end
      // One log fraction bit per squaring; after the first operand, load the second.
      rrpc_pkg::ST_LOGSQ: begin
        frac_r <= {frac_r[18:0], sq_bit_w};
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == 6'(rrpc_pkg::FRAC_BITS - 1) && !second_r) begin
          m_r <= b_r;
        end else begin
          m_r <= sq_bit_w ? sq_w[32:1] : sq_w[31:0];
        end
        if (cnt_r == 6'(rrpc_pkg::FRAC_BITS - 1)) begin
          if (second_r) begin
            lb_r <= lg_w;
          end else begin
            la_r     <= lg_w;
            lz_r     <= '0;
            second_r <= 1'b1;
          end
        end
      end
      rrpc_pkg::ST_PMUL: begin
        p_r   <= mul_p_w[49:0];
        f_r   <= mul_p_w[35:16];
        acc_r <= 32'd1 << 30;
        cnt_r <= '0;
      end
      // Multiply in the ROM root for each set fraction bit.
      rrpc_pkg::ST_EXP: begin
        if (f_r[19]) begin
          acc_r <= mul_p_w[61:30];
        end
        f_r   <= {f_r[18:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
      end
      rrpc_pkg::ST_CMUL: begin
        prod_r <= mul_p_w[63:0];
      end
      rrpc_pkg::ST_ROUND: begin
        if (s_w < 0 && shr_w < 15'sd64) begin
          prod_r <= prod_r + (64'd1 << (shr_w[5:0] - 6'd1));
        end
      end
      rrpc_pkg::ST_SHIFT: begin
        if (s_w > 0) begin
          if (s_w >= 15'sd35) begin
            prod_r <= rrpc_pkg::MAG_CAP;
          end else if (prod_r > (rrpc_pkg::MAG_CAP >> s_w[5:0])) begin
            prod_r <= rrpc_pkg::MAG_CAP;
          end else begin
            prod_r <= prod_r << s_w[5:0];
          end
        end else if (s_w < 0) begin
          if (shr_w >= 15'sd64) begin
            prod_r <= '0;
          end else begin
            prod_r <= prod_r >> shr_w[5:0];
          end
        end
      end
      rrpc_pkg::ST_FINISH: begin
        if (finish_go_w) begin
          out_sample_r <= result_w;
          out_err_r    <= err_r;
          out_last_r   <= last_r;
        end
      end
      default: begin
      end
    endcase
  end

  // A converting beat always starts the sequencer.
  a_conv_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op != rrpc_pkg::OP_STORE) |=> (state_r == rrpc_pkg::ST_PREP))
    else $error("converting beat did not start the sequencer");

  // The magnitude never exceeds the cap when the sum is formed.
  a_mag_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrpc_pkg::ST_FINISH) |-> ({29'd0, mag_r} <= rrpc_pkg::MAG_CAP))
    else $error("magnitude above cap");

  // A zero input range without clipping gives min_out.
  a_range_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error && !clip_r) |-> (out_sample_out == min_out_r))
    else $error("range error result differs from min_out");

endmodule
